FILE: rtl/core/pwn_pkg.sv
// Shared types, codes and helpers for the particle weight normalizer.
// No dependencies; pwn_div and particle_weight_normalizer import this package.
`default_nettype none

package pwn_pkg;

  localparam int OP_W     = 2;
  localparam int WEIGHT_W = 32;
  localparam int FLOOR_W  = 2;
  localparam int INDEX_W  = 10;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int SUM_W    = 42;
  localparam int QBITS    = 31;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_RDPAR = 2'd1;
  localparam logic [OP_W-1:0] OP_RDFLR = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  localparam logic [VAL_W-1:0] ONE_Q31 = 32'h8000_0000;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [WEIGHT_W-1:0] weight;
    logic [FLOOR_W-1:0]  floor;
    logic [INDEX_W-1:0]  index;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [FLOOR_W-1:0] floor_of_particle;
    logic [STAT_W-1:0]  status;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] num;
    logic [SUM_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quo;
  } div_rsp_t;

  // Saturating accumulate of a weight into a 42-bit running sum.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [WEIGHT_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pwn_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module pwn_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pwn_div.sv
// Restoring divider giving floor(num * 2^31 / den), capped at 2^31.
// One quotient bit per cycle; depends on pwn_pkg.
`default_nettype none

module pwn_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pwn_pkg::div_req_t req,
  output pwn_pkg::div_rsp_t      rsp
);

  import pwn_pkg::*;

  logic [SUM_W-1:0] rem_r;
  logic [SUM_W-1:0] den_r;
  logic [QBITS-1:0] quo_r;
  logic [4:0]       cnt_r;
  logic             sat_r;
  logic             busy_r;
  logic             done_r;

  logic [SUM_W:0]   shifted;
  logic [SUM_W:0]   diff;
  logic             take;

  assign shifted = {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, den_r};
  assign take    = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (sat_r || (cnt_r == 5'd1));
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (sat_r || (cnt_r == 5'd1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
      quo_r <= '0;
      cnt_r <= 5'(QBITS);
      sat_r <= (req.num >= req.den);
    end else if (busy_r && !sat_r) begin
      rem_r <= take ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      quo_r <= {quo_r[QBITS-2:0], take};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign rsp = '{done: done_r, quo: (sat_r ? ONE_Q31 : {1'b0, quo_r})};

endmodule

`default_nettype wire

FILE: rtl/core/particle_weight_normalizer.sv
// Top level of the particle weight normalizer: control, sums, result register.
// Depends on pwn_pkg, pwn_ram (particle store) and pwn_div (Q1.31 divider).
//
//   channel   ports                          direction  content
//   in        in_valid, in_ready, in_data    request    pwn_pkg::in_t
//   out       out_valid, out_ready, out_data result     pwn_pkg::out_t
//
// Load, clear and any flagged request need no division; their result goes
// straight to the output register. A floor read starts the divider when it
// is accepted; a particle read first reads the store in state S_RD and then
// starts it. The divider works out the 31 quotient bits in turn; a read whose
// numerator reaches the total skips them and gets one full unit (2^31).
// One request is in work at a time. Reset is synchronous; the particle store
// is not cleared, only the count, total and floor sums are. A finished result
// waits in the output register; if that is still full, one more result is
// parked internally and in_ready stays low until it moves out.
`default_nettype none

module particle_weight_normalizer #(
  parameter int MAX_PARTICLES = 1024,
  parameter int NUM_FLOORS    = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pwn_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pwn_pkg::out_t       out_data
);

  import pwn_pkg::*;

  localparam int AW    = $clog2(MAX_PARTICLES);
  localparam int CW    = $clog2(MAX_PARTICLES + 1);
  localparam int FW    = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
  localparam int RAM_W = WEIGHT_W + FLOOR_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r;
  logic [SUM_W-1:0]   total_r;
  logic [SUM_W-1:0]   fsum_r [NUM_FLOORS];
  logic [FLOOR_W-1:0] pfloor_r;
  out_t               pend_r;
  out_t               out_data_r;
  logic               out_valid_r;

  logic               accept;
  logic               slot_free;
  logic               full;
  logic               idx_ok;
  logic               floor_ok;
  logic               total_zero;
  logic [FW-1:0]      fidx;
  logic               do_load;
  logic               do_clear;
  logic               imm_vld;
  out_t               imm_res;
  logic               res_vld;
  out_t               res;

  logic               ram_we;
  logic               ram_re;
  logic [RAM_W-1:0]   ram_rdata;
  div_req_t           dreq;
  div_rsp_t           drsp;

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign slot_free  = !out_valid_r || out_ready;
  assign full       = (count_r == CW'(MAX_PARTICLES));
  assign idx_ok     = (32'(in_data.index) < 32'(count_r));
  assign floor_ok   = (32'(in_data.floor) < 32'(NUM_FLOORS));
  assign total_zero = (total_r == '0);
  assign fidx       = FW'(in_data.floor);

  assign do_load  = accept && (in_data.op == OP_LOAD) && !full && floor_ok;
  assign do_clear = accept && (in_data.op == OP_CLEAR);
  assign ram_we   = do_load;
  assign ram_re   = accept && (in_data.op == OP_RDPAR) && idx_ok && !total_zero;

  // Requests that need no division answer right away.
  always_comb begin
    imm_vld = 1'b0;
    imm_res = '{value: '0, floor_of_particle: '0, status: ST_OK};
    if (accept) begin
      unique case (in_data.op)
        OP_LOAD: begin
          imm_vld = 1'b1;
          if (full) begin
            imm_res.status = ST_FULL;
          end else if (!floor_ok) begin
            imm_res.status = ST_RANGE;
          end
        end
        OP_RDPAR: begin
          if (!idx_ok) begin
            imm_vld        = 1'b1;
            imm_res.status = ST_RANGE;
          end else if (total_zero) begin
            imm_vld        = 1'b1;
            imm_res.status = ST_ZERO;
          end
        end
        OP_RDFLR: begin
          if (!floor_ok) begin
            imm_vld        = 1'b1;
            imm_res.status = ST_RANGE;
          end else if (total_zero) begin
            imm_vld        = 1'b1;
            imm_res.status = ST_ZERO;
          end
        end
        OP_CLEAR: begin
          imm_vld = 1'b1;
        end
        default: begin
          imm_vld = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = {{(SUM_W - WEIGHT_W){1'b0}}, ram_rdata[WEIGHT_W-1:0]};
    dreq.den   = total_r;
    if (state_r == S_RD) begin
      dreq.start = 1'b1;
    end else if (accept && (in_data.op == OP_RDFLR) && floor_ok && !total_zero) begin
      dreq.start = 1'b1;
      dreq.num   = fsum_r[fidx];
    end
  end

  always_comb begin
    res_vld = 1'b0;
    res     = pend_r;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (imm_vld) begin
          res_vld   = 1'b1;
          res       = imm_res;
          state_nxt = slot_free ? S_IDLE : S_PUSH;
        end else if (ram_re) begin
          state_nxt = S_RD;
        end else if (dreq.start) begin
          state_nxt = S_DIV;
        end
      end
      S_RD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (drsp.done) begin
          res_vld   = 1'b1;
          res       = '{value: drsp.quo, floor_of_particle: pfloor_r, status: ST_OK};
          state_nxt = slot_free ? S_IDLE : S_PUSH;
        end
      end
      S_PUSH: begin
        res_vld   = 1'b1;
        state_nxt = slot_free ? S_IDLE : S_PUSH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
      for (int i = 0; i < NUM_FLOORS; i++) begin
        fsum_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (res_vld && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (do_clear) begin
        count_r <= '0;
        total_r <= '0;
        for (int i = 0; i < NUM_FLOORS; i++) begin
          fsum_r[i] <= '0;
        end
      end else if (do_load) begin
        count_r      <= count_r + CW'(1);
        total_r      <= sat_add(total_r, in_data.weight);
        fsum_r[fidx] <= sat_add(fsum_r[fidx], in_data.weight);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld && slot_free) begin
      out_data_r <= res;
    end
    if (res_vld && !slot_free) begin
      pend_r <= res;
    end
    if (state_r == S_RD) begin
      pfloor_r <= ram_rdata[RAM_W-1:WEIGHT_W];
    end else if (dreq.start) begin
      pfloor_r <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pwn_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_data.floor, in_data.weight}),
    .re    (ram_re),
    .raddr (AW'(in_data.index)),
    .rdata (ram_rdata)
  );

  pwn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(MAX_PARTICLES))
    else $error("particle count exceeds store depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store write and read issued together");

  a_div_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |=> !in_ready)
    else $error("request taken while divider is starting");

  a_push_needs_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |-> out_valid_r)
    else $error("result parked while output register is empty");

  a_total_covers_floor: assert property (@(posedge clk) disable iff (!rst_n)
    floor_ok |-> (total_r >= fsum_r[fidx]))
    else $error("floor sum exceeds total weight");
`endif

endmodule

`default_nettype wire

FILE: tb/particle_weight_normalizer_tb.sv
// Self-checking testbench for particle_weight_normalizer: loads, normalized
// particle and floor reads, clears, store-full and zero-total requests.
// Depends on pwn_pkg and the RTL under rtl/core; predicts every result locally.
module particle_weight_normalizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwn_pkg::*;

  localparam int CAPACITY     = 1024;
  localparam int FLOORS       = 4;
  localparam int RANDOM_ITEMS = 640;
  localparam int STALL_LIMIT  = 5000;
  localparam int SETTLE       = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  particle_weight_normalizer #(
    .MAX_PARTICLES(CAPACITY),
    .NUM_FLOORS(FLOORS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Local copy of the particle set, used to predict every answer.
  logic [WEIGHT_W-1:0] part_weight [CAPACITY];
  logic [FLOOR_W-1:0]  part_floor [CAPACITY];
  int unsigned         n_loaded = 0;
  logic [SUM_W-1:0]    total_weight = '0;
  logic [SUM_W-1:0]    floor_weight [FLOORS];

  in_t  req_q [$];
  out_t answer_q [$];
  logic in_took = 1'b0;
  int unsigned in_idle_pct = 0;
  int unsigned out_stall_pct = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned status_seen [4];
  int unsigned gen_count = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [SUM_W-1:0] add_saturated(input logic [SUM_W-1:0] acc,
                                                     input logic [WEIGHT_W-1:0] w);
    logic [SUM_W:0] wide;
    wide = {1'b0, acc} + (SUM_W + 1)'(w);
    if (wide > {1'b0, {SUM_W{1'b1}}}) return {SUM_W{1'b1}};
    return wide[SUM_W-1:0];
  endfunction

  // Truncated num * 2^31 / den, one full unit when the numerator reaches the total.
  function automatic logic [VAL_W-1:0] q31_ratio(input logic [SUM_W-1:0] num,
                                                 input logic [SUM_W-1:0] den);
    logic [SUM_W+QBITS-1:0] wide;
    if (num >= den) return ONE_Q31;
    wide = {num, {QBITS{1'b0}}} / {{QBITS{1'b0}}, den};
    return wide[VAL_W-1:0];
  endfunction

  function automatic out_t normalize_request(input in_t req);
    out_t res;
    res = '0;
    res.status = ST_OK;
    case (req.op)
      OP_LOAD: begin
        if (n_loaded >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (req.floor >= FLOORS) begin
          res.status = ST_RANGE;
        end else begin
          part_weight[INDEX_W'(n_loaded)] = req.weight;
          part_floor[INDEX_W'(n_loaded)] = req.floor;
          n_loaded++;
          total_weight = add_saturated(total_weight, req.weight);
          floor_weight[req.floor] = add_saturated(floor_weight[req.floor], req.weight);
        end
      end
      OP_RDPAR: begin
        if (req.index >= n_loaded) begin
          res.status = ST_RANGE;
        end else if (total_weight == '0) begin
          res.status = ST_ZERO;
        end else begin
          res.value = q31_ratio(part_weight[req.index], total_weight);
          res.floor_of_particle = part_floor[req.index];
        end
      end
      OP_RDFLR: begin
        if (req.floor >= FLOORS) begin
          res.status = ST_RANGE;
        end else if (total_weight == '0) begin
          res.status = ST_ZERO;
        end else begin
          res.value = q31_ratio(floor_weight[req.floor], total_weight);
        end
      end
      OP_CLEAR: begin
        n_loaded = 0;
        total_weight = '0;
        foreach (floor_weight[f]) floor_weight[f] = '0;
      end
    endcase
    return res;
  endfunction

  // Request driver: a new request goes out only once the previous one was taken.
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (req_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        in_data <= req_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin : predict
      out_t res;
      res = normalize_request(in_data);
      status_seen[res.status]++;
      answer_q = {answer_q, res};
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin : check
      out_t want;
      n_results++;
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        n_errors++;
      end else begin
        want = answer_q.pop_front();
        if (out_data.value !== want.value) begin
          $display("%0t: value mismatch, expected %h, actual %h", $time, want.value,
                   out_data.value);
          n_errors++;
        end
        if (out_data.floor_of_particle !== want.floor_of_particle) begin
          $display("%0t: floor mismatch, expected %0d, actual %0d", $time,
                   want.floor_of_particle, out_data.floor_of_particle);
          n_errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status,
                   out_data.status);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, answer_q.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [WEIGHT_W-1:0] w,
                              input int unsigned flr, input int unsigned idx);
    in_t req;
    req.op = op;
    req.weight = w;
    req.floor = flr[FLOOR_W-1:0];
    req.index = idx[INDEX_W-1:0];
    while (req_q.size() != 0) @(posedge clk);
    req_q = {req_q, req};
    n_requests++;
    // Track the fill level so that reads can aim at or past the count.
    if (op == OP_LOAD) begin
      if (gen_count < CAPACITY) gen_count++;
    end else if (op == OP_CLEAR) begin
      gen_count = 0;
    end
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return {8'h00, 8'($urandom_range(255)), 16'h0000};
      4, 5: return $urandom_range(1, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_index();
    if (gen_count > 0 && ($urandom_range(3) != 0 || gen_count >= CAPACITY))
      return $urandom_range(gen_count - 1, 0);
    return $urandom_range(CAPACITY - 1, gen_count);
  endfunction

  // Field extremes, every operation, zero total and reads past the count.
  // Reads past the count only target slots that were loaded at some point.
  task automatic test_directed();
    in_idle_pct = 27;
    out_stall_pct = 27;
    send_request(OP_RDFLR, $urandom, 0, $urandom);
    send_request(OP_RDFLR, $urandom, 3, $urandom);
    send_request(OP_LOAD, 32'h0000_0000, 2, $urandom);
    send_request(OP_RDPAR, $urandom, $urandom, 0);
    send_request(OP_LOAD, 32'hFFFF_FFFF, 3, $urandom);
    send_request(OP_LOAD, 32'h0000_0001, 1, $urandom);
    send_request(OP_LOAD, 32'h0001_0000, 0, $urandom);
    for (int i = 0; i < 4; i++) send_request(OP_RDPAR, $urandom, $urandom, i);
    for (int f = 0; f < FLOORS; f++) send_request(OP_RDFLR, $urandom, f, $urandom);
    send_request(OP_CLEAR, $urandom, $urandom, $urandom);
    send_request(OP_RDPAR, $urandom, $urandom, 3);
    send_request(OP_RDFLR, $urandom, 1, $urandom);
    send_request(OP_LOAD, 32'hFFFF_FFFF, 0, $urandom);
    send_request(OP_RDPAR, $urandom, $urandom, 0);
    send_request(OP_RDFLR, $urandom, 0, $urandom);
    send_request(OP_RDPAR, $urandom, $urandom, 2);
    wait_drained();
  endtask

  // Fills every slot back to back with no idling on either side, then
  // overloads the store and reads from the far end of it.
  task automatic test_store_full();
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_request(OP_CLEAR, $urandom, $urandom, $urandom);
    for (int i = 0; i < CAPACITY; i++)
      send_request(OP_LOAD, (i % 2 == 0) ? 32'hFFFF_FFFF : $urandom, $urandom, $urandom);
    send_request(OP_LOAD, 32'hFFFF_FFFF, 3, 1023);
    send_request(OP_LOAD, 32'h0000_0000, 0, 0);
    send_request(OP_RDPAR, $urandom, $urandom, 1023);
    send_request(OP_RDPAR, $urandom, $urandom, 0);
    send_request(OP_RDPAR, $urandom, $urandom, 512);
    for (int f = 0; f < FLOORS; f++) send_request(OP_RDFLR, $urandom, f, $urandom);
    wait_drained();
  endtask

  // Mostly well-formed bursts (optional clear, loads, reads) with some noise.
  task automatic test_random();
    int unsigned stop_at;
    int unsigned n_load;
    int unsigned n_read;
    bit zero_set;
    in_idle_pct = 27;
    out_stall_pct = 27;
    stop_at = n_requests + RANDOM_ITEMS;
    while (n_requests < stop_at) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(3) != 0) send_request(OP_CLEAR, $urandom, $urandom, $urandom);
        n_load = $urandom_range(24, 1);
        zero_set = ($urandom_range(9) == 0);
        repeat (n_load)
          send_request(OP_LOAD, zero_set ? '0 : random_weight(), $urandom, $urandom);
        n_read = $urandom_range(10, 1);
        repeat (n_read) begin
          if ($urandom_range(2) != 0) send_request(OP_RDPAR, $urandom, $urandom, pick_index());
          else send_request(OP_RDFLR, $urandom, $urandom, $urandom);
        end
      end else begin
        send_request(OP_W'($urandom), random_weight(), $urandom, $urandom);
      end
    end
    wait_drained();
  endtask

  initial begin
    foreach (floor_weight[f]) floor_weight[f] = '0;
    foreach (status_seen[s]) status_seen[s] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d requests and checked %0d results.", n_requests, n_results);
    $display("Statuses: %0d ok, %0d zero total, %0d store full, %0d out of range.",
             status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_FULL],
             status_seen[ST_RANGE]);
    if (n_errors == 0 && answer_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
